>>> rtl/core/cft_pkg.sv
// Package for the CAN ASCII frame table: result kinds, character constants,
// the table entry layout and the character decoder.
// No dependencies.
`default_nettype none

package cft_pkg;

  localparam int CAN_ID_W = 11;
  localparam int DLC_W    = 4;
  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int POS_W    = 7;
  localparam int ACC_W    = 17;
  localparam int NIB_W    = 5;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  // 'A' - 10: letters decode relative to this offset.
  localparam logic [7:0] CHAR_A_OFF = 8'h37;

  localparam logic [DLC_W-1:0] DLC_MAX = 4'd8;

  typedef enum logic [2:0] {
    KIND_STORED    = 3'd0,
    KIND_IGNORED   = 3'd1,
    KIND_HIT       = 3'd2,
    KIND_UNKNOWN   = 3'd3,
    KIND_TOO_LARGE = 3'd4,
    KIND_ALL       = 3'd5
  } kind_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  data;
    logic [DLC_W-1:0]   dlc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Digits decode as c - '0', everything else as c - 'A' + 10 with no check.
  // The result spans -55..200 and is kept signed.
  function automatic logic signed [8:0] decode_char(input logic [7:0] c);
    logic signed [8:0] d;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = $signed({1'b0, c} - {1'b0, CHAR_ZERO});
    end else begin
      d = $signed({1'b0, c} - {1'b0, CHAR_A_OFF});
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/can_ascii_frame_table.sv
// CAN ASCII frame table, top level: line parser, per-identifier table and
// query path. Uses cft_pkg (kinds, entry layout, decoder) and cft_ram.
`default_nettype none

// How the block is used:
// The input channel (in_*) carries one transaction per byte of a text CAN
// line, or a table query, selected by in_tuser. A carriage return ends a
// line; character 0 is skipped, characters 1 to 3 are the hex identifier,
// character 4 the DLC and the rest data nibbles. At the line end the block
// returns one transaction on out_*: the updated entry (kind stored) or a
// line-ignored marker. A query returns a hit, unknown, too-large or
// query-all transaction. Plain line bytes return nothing.
// Throughput is one input transaction per clock cycle while in_tready is
// high. The accepting edge captures the item in stage 1 and issues the
// table read; stage 2 resolves it and the output register holds the
// result for out_tvalid. The table is one RAM with a single write port, and
// a store is a read-modify-write of its frame counter; a write that
// collides with the read of the next item is forwarded.
// After reset the block runs a clearing pass that writes every table entry
// once, with in_tready low. When the receiver stalls, the output register
// holds its result, one more result item may enter the internal stage, and
// then in_tready drops until the output drains.
module can_ascii_frame_table #(
  parameter int TABLE_DEPTH = 2048,
  parameter int LINE_MAX    = 99
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [23:0]  in_tdata,   // [7:0] rx_byte, [19:8] query_id, [23:20] zero
  input  wire logic [0:0]   in_tuser,   // [0] func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [111:0] out_tdata,  // [10:0] can_id, [14:11] dlc, [78:15] data,
                                        // [110:79] count, [111] zero
  output logic      [2:0]   out_tuser   // [2:0] kind
);

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [cft_pkg::POS_W-1:0]        POS_LIMIT = cft_pkg::POS_W'(LINE_MAX - 1);
  localparam logic signed [cft_pkg::ACC_W-1:0] ID_LIMIT  = cft_pkg::ACC_W'(TABLE_DEPTH);
  localparam logic [11:0]                      Q_LIMIT   = 12'(TABLE_DEPTH);
  localparam logic [AW-1:0]                    LAST_ADDR = AW'(TABLE_DEPTH - 1);

  // Input field unpacking.
  logic        in_func;
  logic [7:0]  in_rx_byte;
  logic [11:0] in_query_id;

  assign in_func     = in_tuser[0];
  assign in_rx_byte  = in_tdata[7:0];
  assign in_query_id = in_tdata[19:8];

  logic accept;
  assign accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------
  // Line parser state. It changes only on accepted line bytes; a query
  // leaves it untouched.
  // ---------------------------------------------------------------------
  logic [cft_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic signed [cft_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [cft_pkg::DLC_W-1:0]        len_r, len_nxt;
  logic [cft_pkg::DATA_W-1:0]       shift_r, shift_nxt;
  logic [cft_pkg::NIB_W-1:0]        nib_r, nib_nxt;

  logic signed [8:0] dec;
  logic              is_cr;
  logic              line_end;
  logic              result_item;
  logic              id_ok;

  assign dec         = cft_pkg::decode_char(in_rx_byte);
  assign is_cr       = (in_rx_byte == cft_pkg::CHAR_CR);
  assign line_end    = accept && !in_func && is_cr;
  assign result_item = accept && (in_func || is_cr);

  // Identifier must be within 1..TABLE_DEPTH-1; the sum may be negative
  // for characters below 'A' that are not digits.
  assign id_ok = (acc_r >= 17'sd1) && (acc_r < ID_LIMIT);

  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    shift_nxt = shift_r;
    nib_nxt   = nib_r;
    if (accept && !in_func) begin
      if (is_cr) begin
        pos_nxt   = '0;
        acc_nxt   = '0;
        len_nxt   = '0;
        shift_nxt = '0;
        nib_nxt   = '0;
      end else if (pos_r < POS_LIMIT) begin
        if (pos_r >= 7'd1 && pos_r <= 7'd3) begin
          acc_nxt = (acc_r <<< 4) + cft_pkg::ACC_W'(dec);
        end else if (pos_r == 7'd4) begin
          if (dec < 9'sd0 || dec > 9'sd8) begin
            len_nxt = cft_pkg::DLC_MAX;
          end else begin
            len_nxt = dec[3:0];
          end
        end else if (pos_r >= 7'd5) begin
          // Only the first 2*DLC nibbles are kept, first one at the top.
          if (nib_r < {len_r, 1'b0} && !nib_r[4]) begin
            shift_nxt[{~nib_r[3:0], 2'b00} +: 4] = dec[3:0];
            nib_nxt = nib_r + 5'd1;
          end
        end
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      acc_r   <= '0;
      len_r   <= '0;
      shift_r <= '0;
      nib_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      shift_r <= shift_nxt;
      nib_r   <= nib_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Clearing pass after reset: every entry is written invalid once.
  // ---------------------------------------------------------------------
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: a result-producing item waits here for its table read data.
  // Stores and lookups are resolved in stage 2; the other kinds are final.
  // ---------------------------------------------------------------------
  logic                       s1_valid_r;
  cft_pkg::kind_t             s1_kind_r, s1_kind_nxt;
  logic [AW-1:0]              s1_addr_r, s1_addr_nxt;
  logic [cft_pkg::DLC_W-1:0]  s1_dlc_r;
  logic [cft_pkg::DATA_W-1:0] s1_data_r;
  logic                       s1_byp_hit_r;
  cft_pkg::entry_t            s1_byp_r;

  logic out_valid_r;
  logic out_free;
  logic adv;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !clr_active_r && (!s1_valid_r || out_free);

  always_comb begin
    s1_kind_nxt = cft_pkg::KIND_IGNORED;
    s1_addr_nxt = acc_r[AW-1:0];
    if (in_func) begin
      s1_addr_nxt = in_query_id[AW-1:0];
      if (in_query_id >= Q_LIMIT) begin
        s1_kind_nxt = cft_pkg::KIND_TOO_LARGE;
      end else if (in_query_id == 12'd0) begin
        s1_kind_nxt = cft_pkg::KIND_ALL;
      end else begin
        s1_kind_nxt = cft_pkg::KIND_HIT;
      end
    end else if (pos_r >= 7'd5 && id_ok) begin
      s1_kind_nxt = cft_pkg::KIND_STORED;
    end
  end

  // Table RAM ports.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  cft_pkg::entry_t ram_wdata;
  cft_pkg::entry_t ram_rdata;
  logic            store_we;
  cft_pkg::entry_t new_entry;

  assign store_we  = adv && (s1_kind_r == cft_pkg::KIND_STORED);
  assign ram_we    = clr_active_r || store_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? cft_pkg::entry_t'('0) : new_entry;

  cft_ram #(
    .WIDTH (cft_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (result_item),
    .raddr (s1_addr_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (result_item) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // The RAM returns old data when the store of the item ahead is written in
  // the same cycle as this read, so that store is captured for forwarding.
  always_ff @(posedge clk) begin
    if (result_item) begin
      s1_kind_r    <= s1_kind_nxt;
      s1_addr_r    <= s1_addr_nxt;
      s1_dlc_r     <= len_r;
      s1_data_r    <= shift_r;
      s1_byp_hit_r <= store_we && (s1_addr_r == s1_addr_nxt);
      s1_byp_r     <= new_entry;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: resolve the entry, update the counter, form the result.
  // ---------------------------------------------------------------------
  cft_pkg::entry_t             ent;
  logic [cft_pkg::COUNT_W-1:0] cnt_new;

  assign ent     = s1_byp_hit_r ? s1_byp_r : ram_rdata;
  assign cnt_new = (ent.valid ? ent.count : '0) + 32'd1;

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.count = cnt_new;
    new_entry.data  = s1_data_r;
    new_entry.dlc   = s1_dlc_r;
  end

  cft_pkg::kind_t               res_kind;
  logic [cft_pkg::CAN_ID_W-1:0] res_id;
  logic [cft_pkg::DLC_W-1:0]    res_dlc;
  logic [cft_pkg::DATA_W-1:0]   res_data;
  logic [cft_pkg::COUNT_W-1:0]  res_count;

  always_comb begin
    res_kind  = s1_kind_r;
    res_id    = '0;
    res_dlc   = '0;
    res_data  = '0;
    res_count = '0;
    case (s1_kind_r)
      cft_pkg::KIND_STORED: begin
        res_id    = cft_pkg::CAN_ID_W'(s1_addr_r);
        res_dlc   = s1_dlc_r;
        res_data  = s1_data_r;
        res_count = cnt_new;
      end
      cft_pkg::KIND_HIT: begin
        res_id = cft_pkg::CAN_ID_W'(s1_addr_r);
        if (ent.valid) begin
          res_dlc   = ent.dlc;
          res_data  = ent.data;
          res_count = ent.count;
        end else begin
          res_kind = cft_pkg::KIND_UNKNOWN;
        end
      end
      default: begin
        res_kind = s1_kind_r;
      end
    endcase
  end

  // Output register.
  cft_pkg::kind_t               out_kind_r;
  logic [cft_pkg::CAN_ID_W-1:0] out_id_r;
  logic [cft_pkg::DLC_W-1:0]    out_dlc_r;
  logic [cft_pkg::DATA_W-1:0]   out_data_r;
  logic [cft_pkg::COUNT_W-1:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r  <= res_kind;
      out_id_r    <= res_id;
      out_dlc_r   <= res_dlc;
      out_data_r  <= res_data;
      out_count_r <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_count_r, out_data_r, out_dlc_r, out_id_r};

`ifndef ASSERT_OFF
  // No transaction is taken while the table is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input accepted during clearing pass");

  // A stalled stage-1 item is neither lost nor overwritten.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_addr_r)
                                   && $stable(s1_kind_r)))
    else $error("stage-1 item changed while stalled");

  // A store result always reports at least one frame.
  a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == cft_pkg::KIND_STORED) |-> (out_tdata[110:79] != 32'd0))
    else $error("store result with zero frame count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/cft_ram.sv
// Generic simple dual-port RAM with one write port and one registered read
// port (read-first on an address collision). No dependencies.
`default_nettype none

module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
